### rtl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and constants for the range fold block: data widths, pipeline
// depth, register codes and the records that travel down the pipeline.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = DATA_W;          // one quotient bit per stage
  localparam int REM_W     = DATA_W + 1;      // remainder is below 2*width
  localparam int MAG_W     = DATA_W + 1;      // count magnitude before clamping
  localparam int LATENCY   = DIV_STEPS + 4;   // accepting edge to result edge
  localparam int CFG_IDX_W = 1;

  localparam logic [MAG_W-1:0]  MAG_POS_LIMIT = MAG_W'(32'h7fff_ffff);
  localparam logic [MAG_W-1:0]  MAG_NEG_LIMIT = MAG_W'(32'h8000_0000);
  localparam logic [DATA_W-1:0] CNT_MAX       = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] CNT_MIN       = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOUND_FIRST  = 1'b0,
    REG_BOUND_SECOND = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_ZERO   = 2'd0,
    MODE_INSIDE = 2'd1,
    MODE_BELOW  = 2'd2,
    MODE_ABOVE  = 2'd3
  } mode_t;

  // ordered interval edges
  typedef struct packed {
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
  } bounds_t;

  // per-item context carried alongside the divider
  typedef struct packed {
    mode_t             mode;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] w;
  } item_t;

  // partial remainder and the shared dividend/quotient shift word
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DATA_W-1:0] dq;
  } div_t;

endpackage

### rtl/rfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rfc_cfg_regs
// Bound registers written over the configuration channel, presented as an
// ordered lower and upper edge.
// ----------------------------------------------------------------------------
module rfc_cfg_regs
  import rfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output bounds_t              bounds
);

  logic [DATA_W-1:0] bound_first_r, bound_first_nxt;
  logic [DATA_W-1:0] bound_second_r, bound_second_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    bound_first_nxt  = bound_first_r;
    bound_second_nxt = bound_second_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOUND_FIRST:  bound_first_nxt  = cfg_data;
        REG_BOUND_SECOND: bound_second_nxt = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_first_r  <= '0;
      bound_second_r <= '0;
    end else begin
      bound_first_r  <= bound_first_nxt;
      bound_second_r <= bound_second_nxt;
    end
  end

  always_comb begin
    if ($signed(bound_first_r) <= $signed(bound_second_r)) begin
      bounds.lo = bound_first_r;
      bounds.hi = bound_second_r;
    end else begin
      bounds.lo = bound_second_r;
      bounds.hi = bound_first_r;
    end
  end

endmodule

### rtl/rfc_front.sv
// ----------------------------------------------------------------------------
// rfc_front
// Two entry stages: capture the sample with the ordered bounds, then classify
// it against the interval and form the distance to the near edge.
// ----------------------------------------------------------------------------
module rfc_front
  import rfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  logic [DATA_W-1:0] sample,
  input  bounds_t           bounds,
  output logic              valid,
  output item_t             item,
  output div_t              div
);

  logic              s1_valid_r;
  logic [DATA_W-1:0] s1_x_r;
  bounds_t           s1_bounds_r;

  logic              s2_valid_r;
  item_t             s2_item_r, s2_item_nxt;
  logic [DATA_W-1:0] s2_dq_r, s2_dq_nxt;

  logic below, zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r      <= sample;
    s1_bounds_r <= bounds;
  end

  assign zero  = (s1_bounds_r.lo == s1_bounds_r.hi);
  assign below = $signed(s1_x_r) < $signed(s1_bounds_r.lo);

  always_comb begin
    s2_item_nxt.w    = s1_bounds_r.hi - s1_bounds_r.lo;
    s2_item_nxt.base = s1_bounds_r.lo;
    s2_dq_nxt        = '0;
    if (zero) begin
      s2_item_nxt.mode = MODE_ZERO;
    end else if (below) begin
      s2_item_nxt.mode = MODE_BELOW;
      s2_dq_nxt        = s1_bounds_r.lo - s1_x_r;
    end else if ($signed(s1_x_r) >= $signed(s1_bounds_r.hi)) begin
      s2_item_nxt.mode = MODE_ABOVE;
      s2_dq_nxt        = s1_x_r - s1_bounds_r.hi;
    end else begin
      // inside: pass the sample straight through
      s2_item_nxt.mode = MODE_INSIDE;
      s2_item_nxt.base = s1_x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_item_r <= s2_item_nxt;
    s2_dq_r   <= s2_dq_nxt;
  end

  assign valid    = s2_valid_r;
  assign item     = s2_item_r;
  assign div.rem  = '0;
  assign div.dq   = s2_dq_r;

endmodule

### rtl/rfc_div_step.sv
// ----------------------------------------------------------------------------
// rfc_div_step
// One restoring division step: brings in the next dividend bit, subtracts the
// period (twice the interval width) where it fits, shifts in the quotient bit.
// ----------------------------------------------------------------------------
module rfc_div_step
  import rfc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_in,
  input  item_t item_in,
  input  div_t  div_in,
  output logic  valid_out,
  output item_t item_out,
  output div_t  div_out
);

  logic              valid_r;
  item_t             item_r;
  div_t              div_r, div_nxt;

  logic [REM_W:0] trial;
  logic [REM_W:0] period;
  logic           fits;
  logic [REM_W:0] diff;

  assign trial  = {div_in.rem, div_in.dq[DATA_W-1]};
  assign period = {1'b0, item_in.w, 1'b0};
  assign fits   = (trial >= period);
  assign diff   = trial - period;

  always_comb begin
    div_nxt.rem = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
    div_nxt.dq  = {div_in.dq[DATA_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_in;
    div_r  <= div_nxt;
  end

  assign valid_out = valid_r;
  assign item_out  = item_r;
  assign div_out   = div_r;

endmodule

### rtl/rfc_post.sv
// ----------------------------------------------------------------------------
// rfc_post
// Two closing stages: pick the mirror offset and the count magnitude from the
// quotient and remainder, then add the offset and clamp the signed count.
// ----------------------------------------------------------------------------
module rfc_post
  import rfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_in,
  input  item_t             item_in,
  input  div_t              div_in,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_folded_value,
  output logic [DATA_W-1:0] out_fold_count
);

  logic [REM_W-1:0] w_ext, per_ext, r;
  logic [REM_W-1:0] per_minus_r, w_minus_r, r_minus_w;
  logic [MAG_W-1:0] q2;
  logic             r_zero, r_le_w, r_lt_w;

  logic              p1_valid_r;
  logic [DATA_W-1:0] p1_base_r;
  logic [DATA_W-1:0] p1_ofs_r, p1_ofs_nxt;
  logic [MAG_W-1:0]  p1_mag_r, p1_mag_nxt;
  logic              p1_neg_r, p1_neg_nxt;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [DATA_W-1:0] out_count_r, out_count_nxt;

  assign r           = div_in.rem;
  assign w_ext       = {1'b0, item_in.w};
  assign per_ext     = {item_in.w, 1'b0};
  assign per_minus_r = per_ext - r;
  assign w_minus_r   = w_ext - r;
  assign r_minus_w   = r - w_ext;
  assign q2          = {div_in.dq, 1'b0};
  assign r_zero      = (r == '0);
  assign r_le_w      = (r <= w_ext);
  assign r_lt_w      = (r < w_ext);

  always_comb begin
    p1_ofs_nxt = '0;
    p1_mag_nxt = '0;
    p1_neg_nxt = 1'b0;
    case (item_in.mode)
      MODE_BELOW: begin
        p1_neg_nxt = 1'b1;
        if (r_zero) begin
          // lands exactly on the lower edge after whole periods
          p1_mag_nxt = q2;
        end else if (r_le_w) begin
          p1_ofs_nxt = r[DATA_W-1:0];
          p1_mag_nxt = q2 + MAG_W'(1);
        end else begin
          p1_ofs_nxt = per_minus_r[DATA_W-1:0];
          p1_mag_nxt = q2 + MAG_W'(2);
        end
      end
      MODE_ABOVE: begin
        if (r_lt_w) begin
          p1_ofs_nxt = w_minus_r[DATA_W-1:0];
          p1_mag_nxt = q2 + MAG_W'(1);
        end else begin
          p1_ofs_nxt = r_minus_w[DATA_W-1:0];
          p1_mag_nxt = q2 + MAG_W'(2);
        end
      end
      default: begin
        p1_ofs_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    p1_base_r <= item_in.base;
    p1_ofs_r  <= p1_ofs_nxt;
    p1_mag_r  <= p1_mag_nxt;
    p1_neg_r  <= p1_neg_nxt;
  end

  always_comb begin
    out_value_nxt = p1_base_r + p1_ofs_r;
    if (p1_neg_r) begin
      out_count_nxt = (p1_mag_r > MAG_NEG_LIMIT) ? CNT_MIN : '0 - p1_mag_r[DATA_W-1:0];
    end else begin
      out_count_nxt = (p1_mag_r > MAG_POS_LIMIT) ? CNT_MAX : p1_mag_r[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_folded_value = out_value_r;
  assign out_fold_count   = out_count_r;

endmodule

### rtl/range_fold_with_count.sv
// ----------------------------------------------------------------------------
// range_fold_with_count
// Reflecting fold of a signed Q16.16 sample into [lo, hi] with a signed,
// saturating half-fold count.
// ----------------------------------------------------------------------------
// Usage
//   Bounds are written on the cfg_ channel (index 0 and 1, either order);
//   cfg_ready is always high. Write them only while no transaction is in
//   flight. The smaller of the two is the lower edge.
//   A sample is taken on every edge with start high and busy low; busy never
//   rises, so one transaction can enter in every cycle.
//   The result shows on out_folded_value and out_fold_count for one cycle
//   with out_valid high, once the sample has passed through two entry
//   stages, 32 division stages (one quotient bit each) and two closing
//   stages. Throughput is one result per cycle, set by that pipeline.
//   The receiver cannot hold results off, so nothing ever backs up.
//   Reset clears both bounds to zero and drops every transaction in flight.
// ----------------------------------------------------------------------------
module range_fold_with_count
  import rfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [DATA_W-1:0]    in_sample_in,
  output logic                 out_valid,
  output logic [DATA_W-1:0]    out_folded_value,
  output logic [DATA_W-1:0]    out_fold_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  bounds_t bounds;
  logic    in_take;

  logic  stg_valid [DIV_STEPS+1];
  item_t stg_item  [DIV_STEPS+1];
  div_t  stg_div   [DIV_STEPS+1];

  assign busy    = 1'b0;
  assign in_take = start & ~busy;

  rfc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bounds    (bounds)
  );

  rfc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .sample  (in_sample_in),
    .bounds  (bounds),
    .valid   (stg_valid[0]),
    .item    (stg_item[0]),
    .div     (stg_div[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rfc_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (stg_valid[i]),
      .item_in   (stg_item[i]),
      .div_in    (stg_div[i]),
      .valid_out (stg_valid[i+1]),
      .item_out  (stg_item[i+1]),
      .div_out   (stg_div[i+1])
    );
  end

  rfc_post u_post (
    .clk              (clk),
    .rst_n            (rst_n),
    .valid_in         (stg_valid[DIV_STEPS]),
    .item_in          (stg_item[DIV_STEPS]),
    .div_in           (stg_div[DIV_STEPS]),
    .out_valid        (out_valid),
    .out_folded_value (out_folded_value),
    .out_fold_count   (out_fold_count)
  );

endmodule

### rtl/rfc_checker.sv
// ----------------------------------------------------------------------------
// rfc_checker
// Port-level checks on the range fold block: fixed latency from accepted
// transaction to result strobe, and a quiet output after reset.
// ----------------------------------------------------------------------------
module rfc_checker
  import rfc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // every accepted transaction gives a strobe a fixed number of cycles later
  a_accept_to_result : assert property (
    @(posedge clk) disable iff (!rst_n)
      (start && !busy) |-> ##LATENCY out_valid
  ) else $error("accepted transaction produced no result strobe");

  // no strobe without a matching transaction
  a_result_from_accept : assert property (
    @(posedge clk) disable iff (!rst_n)
      out_valid |-> $past(start && !busy && rst_n, LATENCY)
  ) else $error("result strobe with no accepted transaction behind it");

  a_reset_quiet : assert property (
    @(posedge clk) !rst_n |=> !out_valid
  ) else $error("result strobe straight after reset");

endmodule

bind range_fold_with_count rfc_checker u_rfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

### tb/range_fold_checker.sv
// ----------------------------------------------------------------------------
// range_fold_checker
// Watches the sample, result and register channels of the range fold block.
// Keeps its own copy of the two bounds, works out the folded value and the
// half-fold count of every accepted sample, and compares each result with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module range_fold_checker
  import rfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [DATA_W-1:0]    in_sample_in,
  input  logic                 out_valid,
  input  logic [DATA_W-1:0]    out_folded_value,
  input  logic [DATA_W-1:0]    out_fold_count,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  localparam longint COUNT_TOP    = 64'sd2147483647;
  localparam longint COUNT_BOTTOM = -64'sd2147483648;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] count;
  } fold_t;

  logic [DATA_W-1:0] bound_first;
  logic [DATA_W-1:0] bound_second;
  fold_t             awaited_folds[$];

  function automatic fold_t fold_sample(logic signed [DATA_W-1:0] bound_a,
                                        logic signed [DATA_W-1:0] bound_b,
                                        logic signed [DATA_W-1:0] sample);
    longint lower;
    longint upper;
    longint x;
    longint span;
    longint y;
    longint cnt;
    longint turns;
    fold_t  r;
    lower = (bound_a <= bound_b) ? longint'(bound_a) : longint'(bound_b);
    upper = (bound_a <= bound_b) ? longint'(bound_b) : longint'(bound_a);
    x     = longint'(sample);
    span  = 2 * (upper - lower);
    y     = x;
    cnt   = 0;
    if (span == 0) begin
      y = lower;
    end else if (x < lower) begin
      // lift by whole periods until at or above the lower edge
      turns = (lower - x + span - 1) / span;
      y     = x + turns * span;
      cnt   = -2 * turns;
      if (y >= upper) begin
        y   = 2 * upper - y;
        cnt = cnt + 1;
      end
    end else if (x >= upper) begin
      turns = (x - upper) / span + 1;
      y     = x - turns * span;
      cnt   = 2 * turns;
      if (y < lower) begin
        y   = 2 * lower - y;
        cnt = cnt - 1;
      end
    end
    if (cnt > COUNT_TOP) cnt = COUNT_TOP;
    if (cnt < COUNT_BOTTOM) cnt = COUNT_BOTTOM;
    r.value = y[DATA_W-1:0];
    r.count = cnt[DATA_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    fold_t want;
    if (!rst_n) begin
      bound_first  = '0;
      bound_second = '0;
      awaited_folds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_BOUND_FIRST:  bound_first  = cfg_data;
          REG_BOUND_SECOND: bound_second = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (awaited_folds.size() == 0) begin
          mismatches++;
          $error("unexpected result: folded_value %0d, fold_count %0d",
                 $signed(out_folded_value), $signed(out_fold_count));
        end else begin
          want = awaited_folds.pop_front();
          if (out_folded_value !== want.value) begin
            mismatches++;
            $error("folded_value: expected %0d, got %0d",
                   $signed(want.value), $signed(out_folded_value));
          end
          if (out_fold_count !== want.count) begin
            mismatches++;
            $error("fold_count: expected %0d, got %0d",
                   $signed(want.count), $signed(out_fold_count));
          end
        end
      end
      if (start && !busy)
        awaited_folds.push_back(fold_sample(bound_first, bound_second, in_sample_in));
    end
    outstanding = awaited_folds.size();
  end

endmodule

### tb/range_fold_with_count_tb.sv
// ----------------------------------------------------------------------------
// range_fold_with_count_tb
// Drives the range fold block: a directed pass over the interval edges,
// mirror hits, zero width, swapped bounds and count saturation, then random
// bounds and samples aimed around the interval, under several idling
// patterns. Results are judged by the checker beside the block.
// ----------------------------------------------------------------------------
module range_fold_with_count_tb;
  import rfc_pkg::*;

  localparam int STALL_LIMIT = 20 * LATENCY;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 start        = 1'b0;
  logic [DATA_W-1:0]    in_sample_in = '0;
  logic                 cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_BOUND_FIRST;
  logic [DATA_W-1:0]    cfg_data     = '0;
  logic                 busy;
  logic                 out_valid;
  logic [DATA_W-1:0]    out_folded_value;
  logic [DATA_W-1:0]    out_fold_count;
  logic                 cfg_ready;
  int                   mismatches;
  int                   outstanding;

  int     idle_pct = 0;
  longint aim_lo   = 0;
  longint aim_hi   = 0;

  wire moving = (start && !busy) || out_valid || (cfg_valid && cfg_ready);

  always #5 clk = ~clk;

  range_fold_with_count dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_sample_in     (in_sample_in),
    .out_valid        (out_valid),
    .out_folded_value (out_folded_value),
    .out_fold_count   (out_fold_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  range_fold_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_sample_in     (in_sample_in),
    .out_valid        (out_valid),
    .out_folded_value (out_folded_value),
    .out_fold_count   (out_fold_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  function automatic logic [DATA_W-1:0] clamp_word(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[DATA_W-1:0];
  endfunction

  // samples mostly land within a few periods of the interval
  function automatic logic [DATA_W-1:0] pick_sample();
    longint          width;
    longint          k;
    longint unsigned draw;
    width = aim_hi - aim_lo;
    k     = longint'($urandom_range(3));
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return '0;
          default: return '1;
        endcase
      end
      4: begin
        // edges and their mirror images, give or take one lsb
        if ($urandom_range(1))
          return clamp_word(aim_hi + k * width + longint'($urandom_range(2)) - 1);
        return clamp_word(aim_lo - k * width + longint'($urandom_range(2)) - 1);
      end
      default: begin
        draw = {$urandom, $urandom};
        return clamp_word(aim_lo - 4 * width - 2 + longint'(draw % (9 * width + 5)));
      end
    endcase
  endfunction

  task automatic random_bounds(output logic [DATA_W-1:0] bnd_first,
                               output logic [DATA_W-1:0] bnd_second);
    longint step;
    step = longint'($urandom_range(1, 16));
    case ($urandom_range(7))
      0, 1: begin
        bnd_first  = $urandom;
        bnd_second = $urandom;
      end
      2, 3: begin
        bnd_first  = $urandom;
        bnd_second = clamp_word(longint'($signed(bnd_first)) + ($urandom_range(1) ? step : -step));
      end
      4, 5: begin
        // within +/-128.0
        bnd_first  = clamp_word(longint'($urandom_range(0, 2**24)) - 64'sd8388608);
        bnd_second = clamp_word(longint'($urandom_range(0, 2**24)) - 64'sd8388608);
      end
      6: begin
        bnd_first  = $urandom;
        bnd_second = bnd_first;
      end
      default: begin
        bnd_first  = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        bnd_second = $urandom;
      end
    endcase
  endtask

  task automatic write_bound(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // bounds change only once every result is back
  task automatic set_bounds(input logic [DATA_W-1:0] bnd_first,
                            input logic [DATA_W-1:0] bnd_second);
    longint a;
    longint b;
    a = longint'($signed(bnd_first));
    b = longint'($signed(bnd_second));
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    if ($urandom_range(1)) begin
      write_bound(REG_BOUND_FIRST, bnd_first);
      write_bound(REG_BOUND_SECOND, bnd_second);
    end else begin
      write_bound(REG_BOUND_SECOND, bnd_second);
      write_bound(REG_BOUND_FIRST, bnd_first);
    end
    cfg_valid <= 1'b0;
    aim_lo = (a <= b) ? a : b;
    aim_hi = (a <= b) ? b : a;
  endtask

  task automatic send_sample(input logic [DATA_W-1:0] sample);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_sample_in <= sample;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] probes[$];
    logic [DATA_W-1:0] bnd_first;
    logic [DATA_W-1:0] bnd_second;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // interval [-3.0, 5.0] with the high edge in the first bound register
    set_bounds(32'h0005_0000, 32'hfffd_0000);
    probes = '{32'hfffd_0000, 32'h0005_0000, 32'h0004_ffff, 32'h0000_0000,
               32'hfffc_ffff, 32'h0005_0001, 32'hfff5_0000, 32'h000d_0000,
               32'h0015_0000, 32'h7fff_ffff, 32'h8000_0000};
    foreach (probes[i]) send_sample(probes[i]);

    // one-lsb interval at the top: count saturates negative
    set_bounds(32'h7fff_fffe, 32'h7fff_ffff);
    probes = '{32'h8000_0000, 32'h0000_0000};
    foreach (probes[i]) send_sample(probes[i]);

    // one-lsb interval at the bottom: count saturates positive
    set_bounds(32'h8000_0001, 32'h8000_0000);
    probes = '{32'h7fff_ffff, 32'h8000_0000};
    foreach (probes[i]) send_sample(probes[i]);

    set_bounds(32'h8000_0000, 32'h7fff_ffff);
    probes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000};
    foreach (probes[i]) send_sample(probes[i]);

    // zero width
    set_bounds(32'h0007_0000, 32'h0007_0000);
    probes = '{32'h8000_0000, 32'h0007_0000, 32'h7fff_ffff};
    foreach (probes[i]) send_sample(probes[i]);

    for (int phase = 0; phase < 20; phase++) begin
      random_bounds(bnd_first, bnd_second);
      set_bounds(bnd_first, bnd_second);
      idle_pct = (phase % 4 == 1) ? 54 : (phase % 4 == 3) ? 27 : 0;
      repeat (33) send_sample(pick_sample());
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // ends the run if no transaction of any kind happens for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (moving)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
rtl/rfc_pkg.sv
rtl/rfc_cfg_regs.sv
rtl/rfc_front.sv
rtl/rfc_div_step.sv
rtl/rfc_post.sv
rtl/range_fold_with_count.sv
rtl/rfc_checker.sv
tb/range_fold_checker.sv
tb/range_fold_with_count_tb.sv
